// ===== rtl/pdis_pkg.sv =====
// Package for the PID controller with deadband and integral separation.
// Holds register indexes, field widths and the configuration register type.
// No dependencies; imported by pid_deadband_integral_separation_top.
package pdis_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;
    localparam int GainW    = 16;
    localparam int LimitW   = 15;
    localparam int SampleW  = 16;
    localparam int ErrW     = SampleW + 1;
    localparam int IntegW   = 32;

    typedef logic [CfgIdxW-1:0]         cfg_idx_t;
    typedef logic [CfgDataW-1:0]        cfg_data_t;
    typedef logic signed [SampleW-1:0]  sample_t;

    localparam cfg_idx_t REG_GAIN_P      = 3'd0;
    localparam cfg_idx_t REG_GAIN_I      = 3'd1;
    localparam cfg_idx_t REG_GAIN_D      = 3'd2;
    localparam cfg_idx_t REG_OUT_LIMIT   = 3'd3;
    localparam cfg_idx_t REG_INTEG_LIMIT = 3'd4;
    localparam cfg_idx_t REG_DEAD_BAND   = 3'd5;
    localparam cfg_idx_t REG_INTEG_SPLIT = 3'd6;

    localparam logic KIND_STEP  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef struct packed {
        logic [GainW-1:0]  gain_p;
        logic [GainW-1:0]  gain_i;
        logic [GainW-1:0]  gain_d;
        logic [LimitW-1:0] out_limit;
        logic [LimitW-1:0] integ_limit;
        logic [GainW-1:0]  dead_band;
        logic [LimitW-1:0] integ_split;
    } cfg_regs_t;

endpackage

// ===== rtl/pid_deadband_integral_separation_top.sv =====
// Top level of the positional PID controller with deadband, anti-windup
// clamp and integral separation. Depends on pdis_pkg.
// Single module: input register, one compute stage, output register.

// The block takes one transfer per cycle on the s_ channel while s_ready is
// high and returns one drive value per item on the m_ channel. An item is
// captured in an input register; the compute stage then computes the error,
// applies the deadband, forms the three gain products in parallel, updates
// the integral and the previous error, and loads the clamped, rounded drive
// into the output register. The loop through the integral and previous-error
// registers closes within the compute stage, which is what allows a new item
// every cycle while the output side is not stalled. A clear item (kind = 1)
// zeroes the integral and the previous error and returns a drive of zero.
// Gains are unsigned Q8.8; a zero output or integral limit turns that clamp
// off, and a zero split width disables integral separation.
// Configuration registers are written through cfg_we, cfg_addr and
// cfg_wdata, and should only be written while no item is in flight.
module pid_deadband_integral_separation_top (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_we,
    input  pdis_pkg::cfg_idx_t   cfg_addr,
    input  pdis_pkg::cfg_data_t  cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_kind,
    input  pdis_pkg::sample_t    s_setpoint,
    input  pdis_pkg::sample_t    s_measured,

    output logic                 m_valid,
    input  logic                 m_ready,
    output pdis_pkg::sample_t    m_drive
);
    import pdis_pkg::*;

    // Configuration registers.
    cfg_regs_t cfg_reg;

    // Input stage.
    logic    in_valid_reg;
    logic    in_kind_reg;
    sample_t in_setpoint_reg;
    sample_t in_measured_reg;

    // Controller state.
    logic signed [ErrW-1:0]   last_error_reg, last_error_next;
    logic signed [IntegW-1:0] integral_reg, integral_next;

    // Output stage.
    logic    out_valid_reg;
    sample_t out_drive_reg, out_drive_next;

    logic advance;

    // The compute stage moves forward whenever the output register is free
    // or its transfer completes in this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_drive = out_drive_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_GAIN_P:      cfg_reg.gain_p      <= cfg_wdata;
                REG_GAIN_I:      cfg_reg.gain_i      <= cfg_wdata;
                REG_GAIN_D:      cfg_reg.gain_d      <= cfg_wdata;
                REG_OUT_LIMIT:   cfg_reg.out_limit   <= cfg_wdata[LimitW-1:0];
                REG_INTEG_LIMIT: cfg_reg.integ_limit <= cfg_wdata[LimitW-1:0];
                REG_DEAD_BAND:   cfg_reg.dead_band   <= cfg_wdata;
                REG_INTEG_SPLIT: cfg_reg.integ_split <= cfg_wdata[LimitW-1:0];
                default: begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    // Compute datapath. Every intermediate is sized so that no product or
    // sum can overflow before the explicit saturation steps.
    logic signed [ErrW-1:0]  err_raw, err;
    logic signed [ErrW:0]    err_ext, db_ext, diff;
    logic signed [33:0]      p_prod, p_lim, p_term;
    logic signed [33:0]      i_prod;
    logic signed [34:0]      acc_full, acc_sat, i_lim;
    logic signed [34:0]      d_term;
    logic signed [36:0]      sum, o_lim, sum_clamped;
    logic signed [37:0]      rounded;
    logic signed [29:0]      res;
    logic signed [ErrW-1:0]  ms_ext, split_ext;
    logic                    separate;

    localparam logic signed [34:0] ACC_MAX = 35'sd2147483647;
    localparam logic signed [34:0] ACC_MIN = -35'sd2147483648;
    localparam logic signed [29:0] DRV_MAX = 30'sd32767;
    localparam logic signed [29:0] DRV_MIN = -30'sd32768;

    always_comb begin
        err_raw = $signed({in_setpoint_reg[SampleW-1], in_setpoint_reg})
                - $signed({in_measured_reg[SampleW-1], in_measured_reg});
        err_ext = {err_raw[ErrW-1], err_raw};
        db_ext  = $signed({2'b00, cfg_reg.dead_band});
        // Errors strictly inside the deadband are forced to zero.
        if ((err_ext > -db_ext) && (err_ext < db_ext)) begin
            err = '0;
        end else begin
            err = err_raw;
        end

        // Proportional term, clamped only when an output limit is set.
        p_prod = $signed({1'b0, cfg_reg.gain_p}) * err;
        p_lim  = $signed({11'b0, cfg_reg.out_limit, 8'b0});
        p_term = p_prod;
        if (cfg_reg.out_limit != '0) begin
            if (p_prod > p_lim) begin
                p_term = p_lim;
            end else if (p_prod < -p_lim) begin
                p_term = -p_lim;
            end
        end

        // Integral update: saturate to 32 bits, then the optional clamp.
        i_prod   = $signed({1'b0, cfg_reg.gain_i}) * err;
        acc_full = {{3{integral_reg[IntegW-1]}}, integral_reg} + {i_prod[33], i_prod};
        if (acc_full > ACC_MAX) begin
            acc_sat = ACC_MAX;
        end else if (acc_full < ACC_MIN) begin
            acc_sat = ACC_MIN;
        end else begin
            acc_sat = acc_full;
        end
        i_lim = $signed({12'b0, cfg_reg.integ_limit, 8'b0});
        if (cfg_reg.integ_limit != '0) begin
            if (acc_sat > i_lim) begin
                acc_sat = i_lim;
            end else if (acc_sat < -i_lim) begin
                acc_sat = -i_lim;
            end
        end

        // Derivative term on the change of the deadbanded error.
        diff   = {err[ErrW-1], err} - {last_error_reg[ErrW-1], last_error_reg};
        d_term = $signed({1'b0, cfg_reg.gain_d}) * diff;

        // Integral separation: a measurement strictly inside the split
        // window drops the integral from the sum and resets it.
        ms_ext    = {in_measured_reg[SampleW-1], in_measured_reg};
        split_ext = $signed({2'b00, cfg_reg.integ_split});
        separate  = (ms_ext < split_ext) && (ms_ext > -split_ext);
        if (separate) begin
            acc_sat = '0;
        end

        sum = {{3{p_term[33]}}, p_term} + {{2{acc_sat[34]}}, acc_sat}
            + {{2{d_term[34]}}, d_term};
        o_lim       = $signed({14'b0, cfg_reg.out_limit, 8'b0});
        sum_clamped = sum;
        if (cfg_reg.out_limit != '0) begin
            if (sum > o_lim) begin
                sum_clamped = o_lim;
            end else if (sum < -o_lim) begin
                sum_clamped = -o_lim;
            end
        end

        // Round half up, then saturate to the 16 bit drive range.
        rounded = {sum_clamped[36], sum_clamped} + 38'sd128;
        res     = rounded[37:8];
        if (res > DRV_MAX) begin
            out_drive_next = DRV_MAX[SampleW-1:0];
        end else if (res < DRV_MIN) begin
            out_drive_next = DRV_MIN[SampleW-1:0];
        end else begin
            out_drive_next = res[SampleW-1:0];
        end
        last_error_next = err;
        integral_next   = acc_sat[IntegW-1:0];

        if (in_kind_reg == KIND_CLEAR) begin
            out_drive_next  = '0;
            last_error_next = '0;
            integral_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_error_reg <= '0;
            integral_reg   <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg  <= 1'b1;
                last_error_reg <= last_error_next;
                integral_reg   <= integral_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg     <= s_kind;
            in_setpoint_reg <= s_setpoint;
            in_measured_reg <= s_measured;
        end
        if (advance) begin
            out_drive_reg <= out_drive_next;
        end
    end

endmodule
